// ===== sv/assert_macros.svh =====
// assertion macros for the lru action table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain implication checked on every clock edge outside reset
`define CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// implication with the consequent checked in the next cycle
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

// ===== sv/iplru_pkg.sv =====
// types and constants of the lru action table
package iplru_pkg;

	localparam int ENTRIES = 1024;
	localparam int ENT_W   = 10;
	localparam int IDX_W   = ENT_W + 1;
	localparam int BUCKETS = 1024;
	localparam int BKT_W   = 10;

	localparam logic [31:0] HASH_A = 32'h9E3779B1;
	localparam logic [31:0] HASH_B = 32'h85EBCA77;

	typedef enum logic [1:0] {
		CMD_LEARN  = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] action;
	} in_t;

	typedef struct packed {
		logic        learned;
		logic        found;
		logic [15:0] action_out;
	} out_t;

	typedef struct packed {
		logic [63:0]      key;
		logic [15:0]      action;
		logic [IDX_W-1:0] cnext;
		logic [ENT_W-1:0] lprev;
		logic [ENT_W-1:0] lnext;
	} entry_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_H1, S_H2, S_FHEAD, S_FCMP, S_LHIT, S_EVRD, S_EVDAT,
		S_RHEAD, S_RWALK, S_UP_RD, S_UP_WR, S_UN_RD, S_UN_WR, S_UT_RD, S_UT_WR,
		S_NEW, S_HD_RD, S_FIN
	} state_t;

endpackage

// ===== sv/ip_pair_lru_action_table_core.sv =====
// lru action table: hash chains and recency list in two synchronous memories
// lookup and learn both walk the key's bucket chain
// a full-table learn walks the evicted entry's chain too; next item taken as done shows
// flush runs the bucket head clearing sweep and empties the recency list
// reset runs the same sweep with busy high, no result given
// one result per item, a one-cycle done strobe; the receiver cannot stall
`include "assert_macros.svh"

module ip_pair_lru_action_table_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  iplru_pkg::in_t   item,
	output logic             busy,
	output logic             done,
	output iplru_pkg::out_t  result
);

	localparam logic [31:0] HASH_A_C = iplru_pkg::HASH_A;
	localparam logic [31:0] HASH_B_C = iplru_pkg::HASH_B;

	iplru_pkg::state_t state_q, state_d;

	iplru_pkg::entry_t ent_mem [iplru_pkg::ENTRIES];
	logic [iplru_pkg::IDX_W-1:0] hd_mem [iplru_pkg::BUCKETS];

	iplru_pkg::entry_t ent_rdata, ent_wdata;
	logic [iplru_pkg::ENT_W-1:0] ent_raddr, ent_waddr;
	logic ent_we;
	logic [iplru_pkg::IDX_W-1:0] hd_rdata, hd_wdata;
	logic [iplru_pkg::BKT_W-1:0] hd_raddr, hd_waddr;
	logic hd_we;

	logic [1:0]  cmd_q;
	logic [63:0] key_q;
	logic [15:0] act_q;
	logic        hsel_q;
	logic [31:0] pa_q, pb_q;
	logic [iplru_pkg::BKT_W-1:0] bkt_q, bkt2_q, clr_q;
	logic [iplru_pkg::IDX_W-1:0] idx_q;
	logic [iplru_pkg::ENT_W-1:0] e_q, lhead_q, ltail_q;
	logic [iplru_pkg::IDX_W-1:0] used_q;
	iplru_pkg::entry_t ent_q;
	logic fresh_q, chg_q, flush_resp_q;

	logic [31:0] hmix;
	logic [iplru_pkg::BKT_W-1:0] hbkt;
	logic [63:0] hkey;
	logic [iplru_pkg::IDX_W-1:0] e_ext;
	logic key_hit;
	logic full;

	assign hkey    = hsel_q ? ent_q.key : key_q;
	assign hmix    = (pa_q ^ pb_q) ^ ((pa_q ^ pb_q) >> 15);
	assign hbkt    = hmix[iplru_pkg::BKT_W-1:0];
	assign e_ext   = {1'b0, e_q};
	assign key_hit = (ent_rdata.key == key_q);
	assign full    = (used_q >= iplru_pkg::IDX_W'(iplru_pkg::ENTRIES));
	assign busy    = (state_q != iplru_pkg::S_IDLE);

	// memories
	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[ent_waddr] <= ent_wdata;
		ent_rdata <= ent_mem[ent_raddr];
	end

	always_ff @(posedge clk) begin
		if (hd_we)
			hd_mem[hd_waddr] <= hd_wdata;
		hd_rdata <= hd_mem[hd_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= iplru_pkg::S_CLR;
		else
			state_q <= state_d;
	end

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		ent_raddr = '0;
		ent_we    = 1'b0;
		ent_waddr = e_q;
		ent_wdata = ent_q;
		hd_raddr  = bkt_q;
		hd_we     = 1'b0;
		hd_waddr  = bkt_q;
		hd_wdata  = e_ext;
		case (state_q)
			iplru_pkg::S_CLR: begin
				hd_we    = 1'b1;
				hd_waddr = clr_q;
				hd_wdata = iplru_pkg::IDX_W'(iplru_pkg::ENTRIES);
				if (clr_q == iplru_pkg::BKT_W'(iplru_pkg::BUCKETS - 1))
					state_d = iplru_pkg::S_IDLE;
			end
			iplru_pkg::S_IDLE: begin
				if (start) begin
					case (item.command)
						iplru_pkg::CMD_LEARN, iplru_pkg::CMD_LOOKUP:
							state_d = iplru_pkg::S_H1;
						iplru_pkg::CMD_FLUSH: state_d = iplru_pkg::S_CLR;
						default: state_d = iplru_pkg::S_IDLE;
					endcase
				end
			end
			iplru_pkg::S_H1: state_d = iplru_pkg::S_H2;
			iplru_pkg::S_H2: begin
				hd_raddr = hbkt;
				state_d  = hsel_q ? iplru_pkg::S_RHEAD : iplru_pkg::S_FHEAD;
			end
			iplru_pkg::S_FHEAD: begin
				ent_raddr = hd_rdata[iplru_pkg::ENT_W-1:0];
				if (!hd_rdata[iplru_pkg::ENT_W])
					state_d = iplru_pkg::S_FCMP;
				else if (cmd_q == iplru_pkg::CMD_LOOKUP)
					state_d = iplru_pkg::S_IDLE;
				else
					state_d = full ? iplru_pkg::S_EVRD : iplru_pkg::S_NEW;
			end
			iplru_pkg::S_FCMP: begin
				ent_raddr = ent_rdata.cnext[iplru_pkg::ENT_W-1:0];
				if (key_hit)
					state_d = (cmd_q == iplru_pkg::CMD_LOOKUP) ? iplru_pkg::S_IDLE
						: iplru_pkg::S_LHIT;
				else if (ent_rdata.cnext[iplru_pkg::ENT_W])
					state_d = (cmd_q == iplru_pkg::CMD_LOOKUP) ? iplru_pkg::S_IDLE
						: (full ? iplru_pkg::S_EVRD : iplru_pkg::S_NEW);
			end
			iplru_pkg::S_LHIT: begin
				if (e_q == ltail_q)
					state_d = iplru_pkg::S_FIN;
				else if (e_q == lhead_q)
					state_d = iplru_pkg::S_UN_RD;
				else
					state_d = iplru_pkg::S_UP_RD;
			end
			iplru_pkg::S_EVRD: begin
				ent_raddr = lhead_q;
				state_d   = iplru_pkg::S_EVDAT;
			end
			iplru_pkg::S_EVDAT: state_d = iplru_pkg::S_H1;
			iplru_pkg::S_RHEAD: begin
				ent_raddr = hd_rdata[iplru_pkg::ENT_W-1:0];
				if (hd_rdata == e_ext) begin
					hd_we    = 1'b1;
					hd_waddr = bkt2_q;
					hd_wdata = ent_q.cnext;
					state_d  = iplru_pkg::S_UN_RD;
				end else if (hd_rdata[iplru_pkg::ENT_W]) begin
					state_d = iplru_pkg::S_UN_RD;
				end else begin
					state_d = iplru_pkg::S_RWALK;
				end
			end
			iplru_pkg::S_RWALK: begin
				ent_raddr = ent_rdata.cnext[iplru_pkg::ENT_W-1:0];
				if (ent_rdata.cnext == e_ext) begin
					ent_we          = 1'b1;
					ent_waddr       = idx_q[iplru_pkg::ENT_W-1:0];
					ent_wdata       = ent_rdata;
					ent_wdata.cnext = ent_q.cnext;
					state_d         = iplru_pkg::S_UN_RD;
				end else if (ent_rdata.cnext[iplru_pkg::ENT_W]) begin
					state_d = iplru_pkg::S_UN_RD;
				end
			end
			iplru_pkg::S_UP_RD: begin
				ent_raddr = ent_q.lprev;
				state_d   = iplru_pkg::S_UP_WR;
			end
			iplru_pkg::S_UP_WR: begin
				ent_we          = 1'b1;
				ent_waddr       = ent_q.lprev;
				ent_wdata       = ent_rdata;
				ent_wdata.lnext = ent_q.lnext;
				state_d         = iplru_pkg::S_UN_RD;
			end
			iplru_pkg::S_UN_RD: begin
				ent_raddr = ent_q.lnext;
				state_d   = iplru_pkg::S_UN_WR;
			end
			iplru_pkg::S_UN_WR: begin
				ent_we          = 1'b1;
				ent_waddr       = ent_q.lnext;
				ent_wdata       = ent_rdata;
				ent_wdata.lprev = ent_q.lprev;
				state_d         = iplru_pkg::S_UT_RD;
			end
			iplru_pkg::S_UT_RD: begin
				ent_raddr = ltail_q;
				state_d   = iplru_pkg::S_UT_WR;
			end
			iplru_pkg::S_UT_WR: begin
				ent_we          = 1'b1;
				ent_waddr       = ltail_q;
				ent_wdata       = ent_rdata;
				ent_wdata.lnext = e_q;
				state_d         = fresh_q ? iplru_pkg::S_HD_RD : iplru_pkg::S_FIN;
			end
			iplru_pkg::S_NEW: begin
				state_d = (used_q == '0) ? iplru_pkg::S_HD_RD : iplru_pkg::S_UT_RD;
			end
			iplru_pkg::S_HD_RD: begin
				hd_raddr = bkt_q;
				state_d  = iplru_pkg::S_FIN;
			end
			iplru_pkg::S_FIN: begin
				ent_we           = 1'b1;
				ent_waddr        = e_q;
				ent_wdata        = ent_q;
				ent_wdata.action = act_q;
				if (fresh_q) begin
					ent_wdata.key   = key_q;
					ent_wdata.cnext = hd_rdata;
					hd_we           = 1'b1;
					hd_waddr        = bkt_q;
					hd_wdata        = e_ext;
				end
				state_d = iplru_pkg::S_IDLE;
			end
			default: state_d = iplru_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			flush_resp_q <= 1'b0;
			used_q       <= '0;
			lhead_q      <= '0;
			ltail_q      <= '0;
			done         <= 1'b0;
			result       <= '0;
		end else begin
			done   <= 1'b0;
			result <= '0;
			case (state_q)
				iplru_pkg::S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == iplru_pkg::BKT_W'(iplru_pkg::BUCKETS - 1)) begin
						flush_resp_q <= 1'b0;
						done         <= flush_resp_q;
					end
				end
				iplru_pkg::S_IDLE: begin
					if (start) begin
						case (item.command)
							iplru_pkg::CMD_LEARN, iplru_pkg::CMD_LOOKUP: ;
							iplru_pkg::CMD_FLUSH: begin
								flush_resp_q <= 1'b1;
								clr_q        <= '0;
								used_q       <= '0;
								lhead_q      <= '0;
								ltail_q      <= '0;
							end
							default: done <= 1'b1;
						endcase
					end
				end
				iplru_pkg::S_FHEAD: begin
					if (hd_rdata[iplru_pkg::ENT_W] && cmd_q == iplru_pkg::CMD_LOOKUP)
						done <= 1'b1;
				end
				iplru_pkg::S_FCMP: begin
					if (cmd_q == iplru_pkg::CMD_LOOKUP) begin
						if (key_hit) begin
							done              <= 1'b1;
							result.found      <= 1'b1;
							result.action_out <= ent_rdata.action;
						end else if (ent_rdata.cnext[iplru_pkg::ENT_W]) begin
							done <= 1'b1;
						end
					end
				end
				iplru_pkg::S_LHIT: begin
					if (e_q != ltail_q && e_q == lhead_q)
						lhead_q <= ent_q.lnext;
				end
				iplru_pkg::S_RHEAD, iplru_pkg::S_RWALK: begin
					if (state_d == iplru_pkg::S_UN_RD)
						lhead_q <= ent_q.lnext;
				end
				iplru_pkg::S_UT_WR: ltail_q <= e_q;
				iplru_pkg::S_NEW: begin
					used_q <= used_q + 1'b1;
					if (used_q == '0) begin
						lhead_q <= used_q[iplru_pkg::ENT_W-1:0];
						ltail_q <= used_q[iplru_pkg::ENT_W-1:0];
					end
				end
				iplru_pkg::S_FIN: begin
					done           <= 1'b1;
					result.learned <= fresh_q | chg_q;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			iplru_pkg::S_IDLE: begin
				cmd_q   <= item.command;
				key_q   <= {item.src_addr, item.dst_addr};
				act_q   <= item.action;
				hsel_q  <= 1'b0;
				fresh_q <= 1'b0;
			end
			iplru_pkg::S_H1: begin
				pa_q <= hkey[63:32] * HASH_A_C;
				pb_q <= hkey[31:0] * HASH_B_C;
			end
			iplru_pkg::S_H2: begin
				if (hsel_q)
					bkt2_q <= hbkt;
				else
					bkt_q <= hbkt;
			end
			iplru_pkg::S_FHEAD: idx_q <= hd_rdata;
			iplru_pkg::S_FCMP: begin
				idx_q <= ent_rdata.cnext;
				if (key_hit) begin
					e_q   <= idx_q[iplru_pkg::ENT_W-1:0];
					ent_q <= ent_rdata;
					chg_q <= (ent_rdata.action != act_q);
				end
			end
			iplru_pkg::S_EVDAT: begin
				e_q     <= lhead_q;
				ent_q   <= ent_rdata;
				hsel_q  <= 1'b1;
				fresh_q <= 1'b1;
			end
			iplru_pkg::S_RHEAD: idx_q <= hd_rdata;
			iplru_pkg::S_RWALK: idx_q <= ent_rdata.cnext;
			iplru_pkg::S_UT_WR: begin
				ent_q.lprev <= ltail_q;
				ent_q.lnext <= e_q;
			end
			iplru_pkg::S_NEW: begin
				e_q     <= used_q[iplru_pkg::ENT_W-1:0];
				fresh_q <= 1'b1;
				if (used_q == '0) begin
					ent_q.lprev <= used_q[iplru_pkg::ENT_W-1:0];
					ent_q.lnext <= used_q[iplru_pkg::ENT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	`CHK_IMPL(a_used_max, 1'b1, used_q <= iplru_pkg::IDX_W'(iplru_pkg::ENTRIES))
	`CHK_IMPL(a_one_entry, used_q == iplru_pkg::IDX_W'(1), lhead_q == ltail_q)
	`CHK_IMPL(a_excl_fields, done, !(result.learned && result.found))
	`CHK_NEXT(a_done_idle, done && state_q != iplru_pkg::S_IDLE, state_q == iplru_pkg::S_IDLE)

endmodule
